// ----- hdl/sfdd_pkg.sv -----
// Shared types, codes and constants of the sensor frame dedupe decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sfdd_pkg;

  localparam int CAND_DEFAULT = 4;

  localparam logic        CMD_ROW  = 1'b0;
  localparam logic        CMD_END  = 1'b1;
  localparam logic [7:0]  FIT_LO   = 8'd72;
  localparam logic [7:0]  FIT_HI   = 8'd73;
  localparam logic [7:0]  MIC_SEED = 8'hA5;
  localparam logic [6:0]  CYCLE_CAP = 7'd64;
  localparam logic [7:0]  REPS_MAX = 8'hFF;

  localparam logic signed [15:0] TMIN_RST = -16'sd200;
  localparam logic signed [15:0] TMAX_RST = 16'sd600;
  localparam logic [7:0]         HLIM_RST = 8'd127;
  localparam logic [7:0]         BLOW_RST = 8'd20;

  localparam logic [7:0] CFG_TMIN = 8'd0;
  localparam logic [7:0] CFG_TMAX = 8'd1;
  localparam logic [7:0] CFG_HLIM = 8'd2;
  localparam logic [7:0] CFG_BLOW = 8'd3;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_MIC   = 2'd1,
    ST_TEMP  = 2'd2,
    ST_HUM   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OV_READ  = 2'd0,
    OV_PLAUS = 2'd1,
    OV_MIC   = 2'd2,
    OV_NONE  = 2'd3
  } overall_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EMIT,
    S_SUMMARY
  } state_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  bit_count;
    logic [31:0] row_head;
    logic [39:0] row_tail;
  } in_t;

  typedef struct packed {
    logic               last;
    status_t            status;
    overall_t           overall;
    logic [2:0]         valid_count;
    logic [23:0]        node_id;
    logic signed [15:0] temperature;
    logic [7:0]         humidity;
    logic [7:0]         battery;
    logic               battery_low;
    logic               pairing;
    logic [6:0]         cycle;
    logic [7:0]         repeat_count;
  } out_t;

  typedef struct packed {
    logic wr;
    logic inc;
    logic clr;
  } tbl_ctrl_t;

endpackage

// ----- hdl/sfdd_table.sv -----
// Candidate table: row storage, repeat counters, fill count and the shared
// 72-bit comparator. Depends on sfdd_pkg.
`timescale 1ns / 1ps

module sfdd_table import sfdd_pkg::*; #(
  parameter int CANDIDATES = CAND_DEFAULT,
  localparam int CW = $clog2(CANDIDATES + 1),
  localparam int AW = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  tbl_ctrl_t     ctrl,
  input  logic [CW-1:0] idx,
  input  logic [31:0]   wr_head,
  input  logic [39:0]   wr_tail,
  output logic [31:0]   rd_head,
  output logic [39:0]   rd_tail,
  output logic [7:0]    rd_reps,
  output logic          match,
  output logic [CW-1:0] used
);

  logic [31:0] heads [CANDIDATES];
  logic [39:0] tails [CANDIDATES];
  logic [7:0]  reps  [CANDIDATES];

  assign rd_head = heads[idx[AW-1:0]];
  assign rd_tail = tails[idx[AW-1:0]];
  assign rd_reps = reps[idx[AW-1:0]];
  assign match   = (rd_head == wr_head) && (rd_tail == wr_tail);

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      heads[used[AW-1:0]] <= wr_head;
      tails[used[AW-1:0]] <= wr_tail;
      reps[used[AW-1:0]]  <= 8'd1;
    end else if (ctrl.inc && (rd_reps != REPS_MAX)) begin
      reps[idx[AW-1:0]] <= rd_reps + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      used <= '0;
    end else if (ctrl.wr) begin
      used <= used + CW'(1);
    end
  end

endmodule

// ----- hdl/sfdd_decode.sv -----
// Decoder for one stored candidate row: whitening removal, integrity check,
// plausibility checks and field extraction. Depends on sfdd_pkg.
`timescale 1ns / 1ps

module sfdd_decode import sfdd_pkg::*; (
  input  logic [31:0]        head,
  input  logic [39:0]        tail,
  input  logic [7:0]         reps,
  input  logic signed [15:0] temp_min,
  input  logic signed [15:0] temp_max,
  input  logic [7:0]         hum_limit,
  input  logic [7:0]         batt_low,
  output out_t               res
);

  logic [71:0]        raw;
  logic [7:0]         inv [9];
  logic [7:0]         d [7];
  logic [7:0]         x;
  logic [10:0]        s;
  logic [7:0]         mic;
  logic signed [15:0] t;

  always_comb begin
    raw = {head, tail};
    for (int i = 0; i < 9; i++) begin
      inv[i] = ~raw[71 - 8 * i -: 8];
    end
    x = '0;
    s = '0;
    for (int i = 0; i < 7; i++) begin
      d[i] = inv[i] ^ inv[7];
      x    = x ^ d[i];
      s    = s + 11'(d[i]);
    end
    mic = MIC_SEED ^ x ^ s[7:0] ^ {5'd0, s[10:8]};
    t   = signed'({d[3], d[4]});

    res              = '0;
    res.status       = ST_VALID;
    res.overall      = OV_READ;
    res.repeat_count = reps;
    if (inv[8] != mic) begin
      res.status = ST_MIC;
    end else if ((t < temp_min) || (t > temp_max)) begin
      res.status = ST_TEMP;
    end else if (d[5] > hum_limit) begin
      res.status = ST_HUM;
    end else begin
      res.node_id     = {d[0], d[1], d[2]};
      res.temperature = t;
      res.humidity    = d[5];
      res.battery     = d[6];
      res.battery_low = d[6] < batt_low;
      res.pairing     = inv[7][7];
      res.cycle       = inv[7][6] ? CYCLE_CAP : {1'b0, inv[7][5:0]};
    end
  end

endmodule

// ----- hdl/sensor_frame_dedupe_decoder_top.sv -----
// Top level of the sensor frame dedupe decoder: sequencer, configuration
// registers and result register. Depends on sfdd_pkg, sfdd_table, sfdd_decode.
`timescale 1ns / 1ps

// Usage
//   Input: drive row and raise start; the item is taken at a clock edge with
//   start high and busy low. A row command (command 0) with bit_count 72 or
//   73 is compared against the candidate table one entry per cycle through a
//   single 72-bit comparator; busy stays high until a match is found or all
//   stored entries are passed. Rows of any other length are dropped at once
//   and leave busy low.
//   An end command (command 1) walks the table in order of first appearance,
//   reading each candidate entry into a register and then decoding it, then
//   emits a summary, busy high throughout. Each result sits on result for
//   exactly one cycle with strobe high; the summary carries last = 1.
//   The receiver cannot stall; results are never held back.
//   Configuration: cfg_valid with cfg_index/cfg_data, always ready. Write
//   only while busy is low. Indexes beyond the register list are ignored.
//   Reset (rst, synchronous) empties the table, restores register defaults
//   and returns to idle. Table contents need no clearing: only entries below
//   the fill count are ever read.

module sensor_frame_dedupe_decoder_top import sfdd_pkg::*; #(
  parameter int CANDIDATES = CAND_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  in_t         row,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output out_t        result,
  output logic        strobe
);

  localparam int CW = $clog2(CANDIDATES + 1);

  // Configuration registers
  logic signed [15:0] temp_min;
  logic signed [15:0] temp_max;
  logic [7:0]         hum_limit;
  logic [7:0]         batt_low;

  // Sequencer state
  state_t        state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] vcnt, vcnt_next;
  logic          any_san, any_san_next;
  logic          any_mic, any_mic_next;
  out_t          result_next;
  logic          strobe_next;
  logic          row_load;
  tbl_ctrl_t     tctrl;

  // Held row and registered table entry
  logic [31:0] row_head;
  logic [39:0] row_tail;
  logic [31:0] ent_head;
  logic [39:0] ent_tail;
  logic [7:0]  ent_reps;

  logic [31:0]   rd_head;
  logic [39:0]   rd_tail;
  logic [7:0]    rd_reps;
  logic          match;
  logic [CW-1:0] used;
  out_t          dec_res;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  sfdd_table #(.CANDIDATES(CANDIDATES)) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (tctrl),
    .idx     (idx),
    .wr_head (row_head),
    .wr_tail (row_tail),
    .rd_head (rd_head),
    .rd_tail (rd_tail),
    .rd_reps (rd_reps),
    .match   (match),
    .used    (used)
  );

  sfdd_decode u_decode (
    .head      (ent_head),
    .tail      (ent_tail),
    .reps      (ent_reps),
    .temp_min  (temp_min),
    .temp_max  (temp_max),
    .hum_limit (hum_limit),
    .batt_low  (batt_low),
    .res       (dec_res)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_min  <= TMIN_RST;
      temp_max  <= TMAX_RST;
      hum_limit <= HLIM_RST;
      batt_low  <= BLOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TMIN: temp_min  <= signed'(cfg_data);
        CFG_TMAX: temp_max  <= signed'(cfg_data);
        CFG_HLIM: hum_limit <= cfg_data[7:0];
        CFG_BLOW: batt_low  <= cfg_data[7:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      vcnt    <= '0;
      any_san <= 1'b0;
      any_mic <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      vcnt    <= vcnt_next;
      any_san <= any_san_next;
      any_mic <= any_mic_next;
      strobe  <= strobe_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    result <= result_next;
    if (row_load) begin
      row_head <= row.row_head;
      row_tail <= row.row_tail;
    end
    if (state == S_READ) begin
      ent_head <= rd_head;
      ent_tail <= rd_tail;
      ent_reps <= rd_reps;
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    vcnt_next    = vcnt;
    any_san_next = any_san;
    any_mic_next = any_mic;
    result_next  = '0;
    strobe_next  = 1'b0;
    row_load     = 1'b0;
    tctrl        = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          if (row.command == CMD_END) begin
            // Open the table walk; an empty table goes straight to summary
            idx_next     = '0;
            vcnt_next    = '0;
            any_san_next = 1'b0;
            any_mic_next = 1'b0;
            state_next   = (used == '0) ? S_SUMMARY : S_READ;
          end else if ((row.bit_count == FIT_LO) || (row.bit_count == FIT_HI)) begin
            row_load   = 1'b1;
            idx_next   = '0;
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (idx == used) begin
          // No match: append when there is room, otherwise drop the row
          tctrl.wr   = (used != CW'(CANDIDATES));
          state_next = S_IDLE;
        end else if (match) begin
          tctrl.inc  = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + CW'(1);
        end
      end

      S_READ: begin
        state_next = S_EMIT;
      end

      S_EMIT: begin
        result_next = dec_res;
        strobe_next = 1'b1;
        case (dec_res.status)
          ST_VALID: vcnt_next    = vcnt + CW'(1);
          ST_MIC:   any_mic_next = 1'b1;
          default:  any_san_next = 1'b1;
        endcase
        idx_next   = idx + CW'(1);
        state_next = ((idx + CW'(1)) == used) ? S_SUMMARY : S_READ;
      end

      S_SUMMARY: begin
        result_next.last        = 1'b1;
        result_next.valid_count = 3'(vcnt);
        if (vcnt != '0) begin
          result_next.overall = OV_READ;
        end else if (any_san) begin
          result_next.overall = OV_PLAUS;
        end else if (any_mic) begin
          result_next.overall = OV_MIC;
        end else begin
          result_next.overall = OV_NONE;
        end
        strobe_next = 1'b1;
        tctrl.clr   = 1'b1;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A result appears only after a decode or summary cycle
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(state) == S_EMIT || $past(state) == S_SUMMARY))
    else $error("result strobe without decode or summary");

  // The summary closes the transmission: table emptied, sequencer idle
  a_summary_clears: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |-> (used == '0 && !busy))
    else $error("table not emptied after summary");

  // Fill count never passes the table depth
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(CANDIDATES))
    else $error("candidate fill count out of range");

  // The walk never emits more candidates than are stored
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (idx < used))
    else $error("table walk past fill count");

endmodule
